// ===== design/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types and constants of the multichannel FIR filter.
// ----------------------------------------------------------------------------
package mcf_pkg;

    localparam int SMP_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int TAPS_W    = 6;
    localparam int CIDX_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_CH    = 4;

    typedef enum logic [1:0] {
        CMD_FILTER = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN = 2'd0,
        REG_TAPS = 2'd1
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_GAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic wr;
        logic rd;
        logic tap_ok;
        logic first;
        logic fin;
    } t_lane_ctl;

endpackage

// ===== design/mcf_ram.sv =====
// ----------------------------------------------------------------------------
// mcf_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mcf_lane.sv =====
// ----------------------------------------------------------------------------
// mcf_lane
// One channel: sample history memory, multiply-accumulate over the taps and
// the gain multiply of the final sum.
// ----------------------------------------------------------------------------
module mcf_lane
    import mcf_pkg::*;
#(
    parameter int MAX_TAPS = 32,
    parameter int ACC_W    = 37,
    parameter int SCL_W    = 54
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic [$clog2(MAX_TAPS)-1:0]   i_wr_addr,
    input  logic [$clog2(MAX_TAPS)-1:0]   i_rd_addr,
    input  logic signed [SMP_W-1:0]       i_sample,
    input  logic signed [SMP_W-1:0]       i_coef,
    input  logic [GAIN_W-1:0]             i_gain,
    output logic signed [SCL_W-1:0]       o_scaled
);

    localparam int PROD_W = 2 * SMP_W;

    logic [SMP_W-1:0]         w_rdata;
    logic signed [SMP_W-1:0]  w_smp;
    logic                     r_s1_v;
    logic                     r_s1_ok;
    logic                     r_s1_first;
    logic                     r_s2_v;
    logic                     r_s2_first;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [SCL_W-1:0]  r_scaled;

    mcf_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_TAPS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr),
        .i_waddr (i_wr_addr),
        .i_wdata (i_sample),
        .i_re    (i_ctl.rd),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    // taps beyond the fill count read as zero history
    assign w_smp      = r_s1_ok ? $signed(w_rdata) : '0;
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s1_ok    <= 1'b0;
            r_s1_first <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s2_first <= 1'b0;
        end else begin
            r_s1_v     <= i_ctl.rd;
            r_s1_ok    <= i_ctl.tap_ok;
            r_s1_first <= i_ctl.first;
            r_s2_v     <= r_s1_v;
            r_s2_first <= r_s1_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_prod <= w_smp * i_coef;
        end
        if (r_s2_v) begin
            r_acc <= r_s2_first ? w_prod_ext : r_acc + w_prod_ext;
        end
        if (i_ctl.fin) begin
            r_scaled <= r_acc * $signed({1'b0, i_gain});
        end
    end

    assign o_scaled = r_scaled;

endmodule

// ===== design/mcf_merge.sv =====
// ----------------------------------------------------------------------------
// mcf_merge
// Rounds and saturates the lane results, merges the clip flags and holds
// the output word until it is taken.
// ----------------------------------------------------------------------------
module mcf_merge
    import mcf_pkg::*;
#(
    parameter int LANES = 4,
    parameter int SCL_W = 54
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic signed [SCL_W-1:0]     i_scaled [LANES],
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [OUT_CH-1:0][SMP_W-1:0] o_data,
    output logic                        o_sat
);

    localparam logic signed [SCL_W-1:0] RND_HALF = {{(SCL_W-23){1'b0}}, 1'b1, 22'b0};
    localparam logic signed [SCL_W-1:0] SAT_HI   = {{(SCL_W-15){1'b0}}, 15'h7fff};
    localparam logic signed [SCL_W-1:0] SAT_LO   = {{(SCL_W-15){1'b1}}, 15'h0000};

    logic [OUT_CH-1:0][SMP_W-1:0] w_data;
    logic [LANES-1:0]             w_clip;
    logic signed [SCL_W-1:0]      w_rnd [LANES];
    logic                         r_valid;
    logic [OUT_CH-1:0][SMP_W-1:0] r_data;
    logic                         r_sat;

    always_comb begin
        w_data = '0;
        for (int c = 0; c < LANES; c++) begin
            w_rnd[c] = (i_scaled[c] + RND_HALF) >>> 23;
            if (w_rnd[c] > SAT_HI) begin
                w_data[c] = SAT_HI[SMP_W-1:0];
                w_clip[c] = 1'b1;
            end else if (w_rnd[c] < SAT_LO) begin
                w_data[c] = SAT_LO[SMP_W-1:0];
                w_clip[c] = 1'b1;
            end else begin
                w_data[c] = w_rnd[c][SMP_W-1:0];
                w_clip[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= w_data;
            r_sat  <= |w_clip;
        end
    end

    assign o_out_valid = r_valid;
    assign o_data      = r_data;
    assign o_sat       = r_sat;

endmodule

// ===== design/multichannel_fir_filter.sv =====
// ----------------------------------------------------------------------------
// multichannel_fir_filter
// Multichannel direct-form FIR filter with a shared coefficient table,
// Q8.8 output gain, rounding and saturation to Q1.15.
// ----------------------------------------------------------------------------
// A filter word occupies the block from acceptance until the input is ready
// again: it stores the samples, then for each tap in use (taps = taps_in_use
// limited to MAX_TAPS) every channel lane does one multiply-accumulate out
// of its dual-port history memory and the shared coefficient memory; then
// the pipeline drains, the gain multiply follows and the output register
// is loaded. Load and clear words return no word. The result sits in an
// output register, so the next word is taken while it waits; a result that
// finishes while an earlier one is still waiting holds the block, input
// included, until that earlier word is taken. History clear after reset or
// by a clear word is immediate (fill count); there is no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_fir_filter
    import mcf_pkg::*;
#(
    parameter int MAX_TAPS = 32,
    parameter int CHANNELS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_command,
    input  logic [CIDX_W-1:0]      i_coef_index,
    input  logic signed [SMP_W-1:0] i_coef_value,
    input  logic signed [SMP_W-1:0] i_sample_0,
    input  logic signed [SMP_W-1:0] i_sample_1,
    input  logic signed [SMP_W-1:0] i_sample_2,
    input  logic signed [SMP_W-1:0] i_sample_3,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [SMP_W-1:0] o_out_0,
    output logic signed [SMP_W-1:0] o_out_1,
    output logic signed [SMP_W-1:0] o_out_2,
    output logic signed [SMP_W-1:0] o_out_3,
    output logic                   o_saturated,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    localparam int LANES = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
    localparam int TAP_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int IDX_W = (TAP_W > CIDX_W) ? TAP_W : CIDX_W;
    localparam int ACC_W = 2 * SMP_W + TAP_W;
    localparam int SCL_W = ACC_W + GAIN_W + 1;
    localparam logic [TAP_W-1:0] POS_LAST  = TAP_W'(MAX_TAPS - 1);
    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(MAX_TAPS);

    t_state                r_state, n_state;
    logic [TAP_W-1:0]      r_pos, n_pos;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [TAP_W-1:0]      r_rd, n_rd;
    logic [TAP_W-1:0]      r_i, n_i;
    logic [CNT_W-1:0]      r_ntaps, n_ntaps;
    logic                  r_drain, n_drain;
    logic [GAIN_W-1:0]     r_gain;
    logic [TAPS_W-1:0]     r_taps;
    logic [MAX_TAPS-1:0]   r_coef_vld;
    logic                  r_coef_ok;

    t_lane_ctl             w_ctl;
    logic                  w_in_acc;
    logic                  w_coef_we;
    logic                  w_out_load;
    logic                  w_idx_ok;
    logic [IDX_W-1:0]      w_idx_ext;
    logic [TAP_W-1:0]      w_coef_addr;
    logic [CNT_W-1:0]      w_taps_eff;
    logic [SMP_W-1:0]      w_coef_rdata;
    logic signed [SMP_W-1:0] w_coef;
    logic signed [SMP_W-1:0] w_smp [OUT_CH];
    logic signed [SCL_W-1:0] w_scaled [LANES];
    logic [OUT_CH-1:0][SMP_W-1:0] w_out;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_idx_ext   = IDX_W'(i_coef_index);
    assign w_coef_addr = w_idx_ext[TAP_W-1:0];
    assign w_idx_ok    = 32'(i_coef_index) < MAX_TAPS;
    assign w_taps_eff  = (32'(r_taps) > MAX_TAPS) ? FILL_FULL : CNT_W'(r_taps);

    assign w_smp[0] = i_sample_0;
    assign w_smp[1] = i_sample_1;
    assign w_smp[2] = i_sample_2;
    assign w_smp[3] = i_sample_3;

    // configuration registers; zero writes are dropped (taps: zero in the low TAPS_W bits)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_W'(256);
            r_taps <= TAPS_W'(32);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg'(i_cfg_index))
                REG_GAIN: begin
                    if (i_cfg_data != '0) begin
                        r_gain <= i_cfg_data;
                    end
                end
                REG_TAPS: begin
                    if (i_cfg_data[TAPS_W-1:0] != '0) begin
                        r_taps <= i_cfg_data[TAPS_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_fill     <= '0;
            r_rd       <= '0;
            r_i        <= '0;
            r_ntaps    <= '0;
            r_drain    <= 1'b0;
            r_coef_vld <= '0;
            r_coef_ok  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_fill  <= n_fill;
            r_rd    <= n_rd;
            r_i     <= n_i;
            r_ntaps <= n_ntaps;
            r_drain <= n_drain;
            if (w_coef_we) begin
                r_coef_vld[w_coef_addr] <= 1'b1;
            end
            if (w_ctl.rd) begin
                r_coef_ok <= r_coef_vld[r_i];
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_fill     = r_fill;
        n_rd       = r_rd;
        n_i        = r_i;
        n_ntaps    = r_ntaps;
        n_drain    = r_drain;
        w_ctl      = '0;
        w_coef_we  = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (t_cmd'(i_command))
                        CMD_FILTER: begin
                            w_ctl.wr = 1'b1;
                            n_rd     = r_pos;
                            n_pos    = (r_pos == POS_LAST) ? '0 : r_pos + TAP_W'(1);
                            n_fill   = (r_fill == FILL_FULL) ? r_fill : r_fill + CNT_W'(1);
                            n_i      = '0;
                            n_ntaps  = w_taps_eff;
                            n_state  = S_RUN;
                        end
                        CMD_LOAD: begin
                            w_coef_we = w_idx_ok;
                        end
                        CMD_CLEAR: begin
                            n_pos  = '0;
                            n_fill = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                w_ctl.rd     = 1'b1;
                w_ctl.tap_ok = CNT_W'(r_i) < r_fill;
                w_ctl.first  = (r_i == '0);
                n_rd         = (r_rd == '0) ? POS_LAST : r_rd - TAP_W'(1);
                n_i          = r_i + TAP_W'(1);
                if (CNT_W'(r_i) + CNT_W'(1) == r_ntaps) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain) begin
                    n_state = S_GAIN;
                end else begin
                    n_drain = 1'b1;
                end
            end
            S_GAIN: begin
                w_ctl.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!o_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    mcf_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_TAPS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_addr),
        .i_wdata (i_coef_value),
        .i_re    (w_ctl.rd),
        .i_raddr (r_i),
        .o_rdata (w_coef_rdata)
    );

    // never-loaded coefficients read as zero
    assign w_coef = r_coef_ok ? $signed(w_coef_rdata) : '0;

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        mcf_lane #(
            .MAX_TAPS (MAX_TAPS),
            .ACC_W    (ACC_W),
            .SCL_W    (SCL_W)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_wr_addr (r_pos),
            .i_rd_addr (r_rd),
            .i_sample  (w_smp[c]),
            .i_coef    (w_coef),
            .i_gain    (r_gain),
            .o_scaled  (w_scaled[c])
        );
    end

    mcf_merge #(
        .LANES (LANES),
        .SCL_W (SCL_W)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_out_load),
        .i_scaled    (w_scaled),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_data      (w_out),
        .o_sat       (o_saturated)
    );

    assign o_out_0 = w_out[0];
    assign o_out_1 = w_out[1];
    assign o_out_2 = w_out[2];
    assign o_out_3 = w_out[3];

endmodule

// ===== design/mcf_checker.sv =====
// ----------------------------------------------------------------------------
// mcf_checker
// Port-level checks of the multichannel FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module mcf_checker
    import mcf_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic [1:0]              i_command,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [SMP_W-1:0] o_out_0,
    input logic signed [SMP_W-1:0] o_out_1,
    input logic signed [SMP_W-1:0] o_out_2,
    input logic signed [SMP_W-1:0] o_out_3,
    input logic                    o_saturated
);

    // a filter word keeps the input closed while it is computed
    a_busy_after_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_command == CMD_FILTER) |=> !o_in_ready)
        else $error("input ready right after a filter word");

    // load, clear and unused commands never produce a result
    a_no_result_for_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_command != CMD_FILTER) |=> !$rose(o_out_valid))
        else $error("result after a non-filter word");

    // a new result only appears at the end of a busy period
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without a filter word in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_0) && $stable(o_out_1) && $stable(o_out_2)
             && $stable(o_out_3) && $stable(o_saturated)))
        else $error("output word changed while stalled");

endmodule

bind multichannel_fir_filter mcf_checker u_mcf_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel FIR filter. Drives sample, load,
// clear and unused words under random valid/ready gaps and register settings,
// predicts each output word in a bit-exact fixed-point tracker and compares
// every field of each returned word in order.
// ----------------------------------------------------------------------------
module testbench;
    import mcf_pkg::*;

    localparam int NTAPS      = 32;
    localparam int NCH        = 4;
    localparam int LIMIT      = 1000000;
    localparam int DRAIN_CYC  = 50;
    localparam int RX_HOLD    = 400;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic signed [SMP_W-1:0] ch [NCH];
        logic                    sat;
    } t_fir_word;

    class t_fir_ledger;
        logic signed [SMP_W-1:0] hist [NCH][NTAPS];
        logic signed [SMP_W-1:0] coefs [NTAPS];
        int                      wr_pos;
        int unsigned             gain_q88;
        int unsigned             taps_reg;
        t_fir_word               pending_outputs [$];
        int                      errors;

        function new();
            foreach (hist[c, i]) hist[c][i] = '0;
            foreach (coefs[i]) coefs[i] = '0;
            wr_pos   = 0;
            gain_q88 = 256;
            taps_reg = 32;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == REG_GAIN) begin
                if (data != 0) gain_q88 = data;
            end else if (idx == REG_TAPS) begin
                if (data[5:0] != 0) taps_reg = data[5:0];
            end
        endfunction

        function void take_word(logic [1:0] cmd, logic [CIDX_W-1:0] cidx,
                                logic signed [SMP_W-1:0] cval,
                                logic signed [SMP_W-1:0] smp [NCH]);
            t_fir_word w;
            longint    acc;
            longint    v;
            int        n;
            w.sat = 1'b0;
            case (cmd)
                CMD_LOAD: begin
                    coefs[cidx] = cval;
                end
                CMD_CLEAR: begin
                    foreach (hist[c, i]) hist[c][i] = '0;
                    wr_pos = 0;
                end
                CMD_FILTER: begin
                    n = (taps_reg > NTAPS) ? NTAPS : taps_reg;
                    for (int c = 0; c < NCH; c++) begin
                        hist[c][wr_pos] = smp[c];
                        acc = 0;
                        for (int i = 0; i < n; i++)
                            acc += longint'(hist[c][(wr_pos + NTAPS - i) % NTAPS])
                                   * longint'(coefs[i]);
                        v = (acc * longint'(gain_q88) + (longint'(1) << 22)) >>> 23;
                        if (v > 32767) begin
                            v = 32767;
                            w.sat = 1'b1;
                        end else if (v < -32768) begin
                            v = -32768;
                            w.sat = 1'b1;
                        end
                        w.ch[c] = v[SMP_W-1:0];
                    end
                    wr_pos = (wr_pos + 1) % NTAPS;
                    pending_outputs = {pending_outputs, w};
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic signed [SMP_W-1:0] got [NCH], logic got_sat);
            t_fir_word w;
            if (pending_outputs.size() == 0) begin
                $error("output word with none expected");
                errors++;
                return;
            end
            w = pending_outputs.pop_front();
            for (int c = 0; c < NCH; c++)
                if (got[c] !== w.ch[c]) begin
                    $error("out_%0d: expected %0d, got %0d", c, w.ch[c], got[c]);
                    errors++;
                end
            if (got_sat !== w.sat) begin
                $error("saturated: expected %0d, got %0d", w.sat, got_sat);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_outputs.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [1:0]              i_command;
    logic [CIDX_W-1:0]       i_coef_index;
    logic signed [SMP_W-1:0] i_coef_value;
    logic signed [SMP_W-1:0] i_sample_0;
    logic signed [SMP_W-1:0] i_sample_1;
    logic signed [SMP_W-1:0] i_sample_2;
    logic signed [SMP_W-1:0] i_sample_3;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [SMP_W-1:0] o_out_0;
    logic signed [SMP_W-1:0] o_out_1;
    logic signed [SMP_W-1:0] o_out_2;
    logic signed [SMP_W-1:0] o_out_3;
    logic                    o_saturated;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [15:0]             i_cfg_data;

    t_fir_ledger led = new();
    bit        idle_on = 1'b1;
    bit        rx_hold_req = 1'b0;
    int        cycle_cnt = 0;

    multichannel_fir_filter #(
        .MAX_TAPS (NTAPS),
        .CHANNELS (NCH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_sample_0   (i_sample_0),
        .i_sample_1   (i_sample_1),
        .i_sample_2   (i_sample_2),
        .i_sample_3   (i_sample_3),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_0      (o_out_0),
        .o_out_1      (o_out_1),
        .o_out_2      (o_out_2),
        .o_out_3      (o_out_3),
        .o_saturated  (o_saturated),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin : monitor
        logic signed [SMP_W-1:0] smp [NCH];
        logic signed [SMP_W-1:0] got [NCH];
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                led.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                smp[0] = i_sample_0;
                smp[1] = i_sample_1;
                smp[2] = i_sample_2;
                smp[3] = i_sample_3;
                led.take_word(i_command, i_coef_index, i_coef_value, smp);
            end
            if (o_out_valid && i_out_ready) begin
                got[0] = o_out_0;
                got[1] = o_out_1;
                got[2] = o_out_2;
                got[3] = o_out_3;
                led.check_word(got, o_saturated);
            end
        end
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int rx_stall;
        int held;
        rx_stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_out_ready = 1'b0;
                held = 0;
                while (held < RX_HOLD) begin
                    @(negedge i_clk);
                    held++;
                end
                rx_hold_req = 1'b0;
                i_out_ready = 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 25) begin
                rx_stall = idle_gap();
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    function automatic logic [15:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'h7FFF;
        if (r < 16) return 16'h8000;
        if (r < 22) return 16'h0000;
        if (r < 45) return 16'($urandom_range(0, 511) - 256);
        return 16'($urandom);
    endfunction

    function automatic logic [1:0] rand_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82) return CMD_FILTER;
        if (r < 93) return CMD_LOAD;
        if (r < 97) return CMD_CLEAR;
        return CMD_UNUSED;
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_word(input logic [1:0] cmd, input logic [4:0] cidx,
                             input logic [15:0] cval, input logic [15:0] s0,
                             input logic [15:0] s1, input logic [15:0] s2,
                             input logic [15:0] s3);
        int gap;
        i_command    = cmd;
        i_coef_index = cidx;
        i_coef_value = cval;
        i_sample_0   = s0;
        i_sample_1   = s1;
        i_sample_2   = s2;
        i_sample_3   = s3;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random();
        send_word(rand_command(), 5'($urandom), rand_value(), rand_value(),
                  rand_value(), rand_value(), rand_value());
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // drop valid, wait for all output words, then let the pipeline drain
    task automatic settle();
        i_in_valid = 1'b0;
        while (led.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [15:0] gain, input logic [15:0] taps,
                             input bit idle, input bit hold, input int words);
        settle();
        cfg_write(REG_GAIN, gain);
        cfg_write(REG_TAPS, taps);
        idle_on = idle;
        if (hold) rx_hold_req = 1'b1;
        repeat (words) send_random();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_FILTER;
        i_coef_index = '0;
        i_coef_value = '0;
        i_sample_0   = '0;
        i_sample_1   = '0;
        i_sample_2   = '0;
        i_sample_3   = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_GAIN;
        i_cfg_data   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset settings, extremes, all commands
        send_word(CMD_FILTER, 5'd0, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF);
        send_word(CMD_LOAD, 5'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        send_word(CMD_LOAD, 5'd31, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_word(CMD_LOAD, 5'd1, 16'h4000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(CMD_FILTER, 5'd31, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        send_word(CMD_FILTER, 5'd0, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_word(CMD_UNUSED, 5'd31, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_word(CMD_FILTER, 5'd0, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_word(CMD_CLEAR, 5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(CMD_FILTER, 5'd0, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA);
        send_word(CMD_LOAD, 5'd15, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_word(CMD_LOAD, 5'd2, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        for (int k = 0; k < 10; k++)
            send_word(CMD_FILTER, 5'($urandom), 16'($urandom), rand_value(),
                      rand_value(), rand_value(), rand_value());
        send_word(CMD_CLEAR, 5'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_word(CMD_FILTER, 5'd0, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);

        // random phases across register settings
        run_phase(16'd256, 16'd32, 1'b1, 1'b0, 190);
        run_phase(16'hFFFF, 16'd1, 1'b0, 1'b0, 190);
        run_phase(16'd1, 16'd63, 1'b1, 1'b0, 190);
        settle();
        cfg_write(REG_SPARE_A, 16'($urandom));
        cfg_write(REG_SPARE_B, 16'($urandom));
        run_phase(16'd0, 16'd0, 1'b1, 1'b0, 190);
        run_phase(16'd300, 16'd64, 1'b1, 1'b1, 190);
        run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 32)),
                  1'b1, 1'b0, 190);
        run_phase(16'd16, 16'd2, 1'b0, 1'b0, 190);
        run_phase(16'($urandom_range(1, 65535)), 16'd17, 1'b1, 1'b0, 190);

        settle();
        if (led.errors == 0 && led.pending_count() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
